FILE: rtl/dedup_max_priority_queue_assert.svh
// assertion macros for the keyed priority table
`ifndef DEDUP_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define DEDUP_MAX_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define DMPQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dmpq assertion failed");
// next-cycle implication, checked outside reset
`define DMPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dmpq assertion failed");
`else
`define DMPQ_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define DMPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/dmpq_pkg.sv
// shared types and constants for the keyed priority table
`timescale 1ns / 1ps
package dmpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RM_W        = 5;

    // q8.8 value of -1.0
    localparam logic signed [15:0] REL_FLOOR = -16'sd256;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_EXPIRE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_TICK   = 3'd5;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_MERGED   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_PUSH,
        CELL_DROP,
        CELL_EXPIRE,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        logic               valid;
        logic [15:0]        key;
        logic signed [15:0] rel;
        logic [31:0]        birth;
    } slot_t;

    typedef struct packed {
        logic               found;
        logic signed [15:0] rel;
        logic [15:0]        key;
        logic [IDX_W-1:0]   idx;
    } tok_t;

    typedef struct packed {
        cell_op_t           op;
        logic [15:0]        key;
        logic signed [15:0] rel;
        logic [31:0]        time_now;
        logic [15:0]        expiry;
        logic [IDX_W-1:0]   drop_idx;
    } cell_cmd_t;

    function automatic logic [RM_W-1:0] fit_removed(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+RM_W-1:0] wide;
        wide = {{RM_W{1'b0}}, cnt};
        return wide[RM_W-1:0];
    endfunction

endpackage

FILE: rtl/dedup_max_priority_queue.sv
// keyed max-priority table built as a row of slot cells
// push, clear, tick, spare codes and remove-expired with expiry off pass the execute
// state and then the result state; pop and peek wait while the max token walks the row
// one cell per cycle; remove-expired squeezes out expired entries until none is left
// one item in flight: the next beat is taken the cycle after the result is loaded into
// the output register, and later while m_ready holds off
// reset (aresetn low, synchronous): table empty, time zero, expiry_ticks zero
`timescale 1ns / 1ps
`include "dedup_max_priority_queue_assert.svh"
module dedup_max_priority_queue (
    input  logic               aclk,
    input  logic               aresetn,
    // operation beats
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_op,
    input  logic [15:0]        s_action_key,
    input  logic signed [15:0] s_relevance,
    // result beats
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [15:0]        m_out_key,
    output logic signed [15:0] m_out_relevance,
    output logic [4:0]         m_removed_count,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH = dmpq_pkg::QUEUE_DEPTH;
    localparam int IDX_W = dmpq_pkg::IDX_W;
    localparam int CNT_W = dmpq_pkg::CNT_W;
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EXPIRE,
        ST_RESULT
    } state_t;

    state_t                state_reg;

    // captured operation
    logic [2:0]            op_reg;
    logic [15:0]           key_reg;
    logic signed [15:0]    rel_reg;

    // table bookkeeping
    logic [31:0]           time_reg;
    logic [15:0]           expiry_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      scan_cnt_reg;

    // pending result
    logic [2:0]            res_status_reg;
    logic [15:0]           res_key_reg;
    logic signed [15:0]    res_rel_reg;
    logic [CNT_W-1:0]      res_removed_reg;

    // output register
    logic                  m_valid_reg;
    logic [2:0]            m_status_reg;
    logic [15:0]           m_key_reg;
    logic signed [15:0]    m_rel_reg;
    logic [4:0]            m_removed_reg;

    // cell row wiring
    dmpq_pkg::cell_cmd_t   cmd;
    dmpq_pkg::slot_t       slots [DEPTH];
    dmpq_pkg::tok_t        toks  [DEPTH];
    logic [DEPTH:0]        flag_chain;
    logic [DEPTH-1:0]      valid_vec;
    dmpq_pkg::tok_t        tok_last;
    logic                  any_flag;
    logic                  cfg_write;

    localparam dmpq_pkg::slot_t HEAD_SLOT =
        '{valid: 1'b1, key: 16'd0, rel: 16'sd0, birth: 32'd0};
    localparam dmpq_pkg::slot_t TAIL_SLOT =
        '{valid: 1'b0, key: 16'd0, rel: 16'sd0, birth: 32'd0};
    localparam dmpq_pkg::tok_t TOK_INIT =
        '{found: 1'b0, rel: dmpq_pkg::REL_FLOOR, key: 16'd0, idx: '0};

    assign flag_chain[0] = 1'b0;
    assign tok_last      = toks[DEPTH-1];
    assign any_flag      = flag_chain[DEPTH];

    // row of cells; the left neighbor of cell 0 counts as occupied so a push
    // into an empty table lands there, the right neighbor of the last cell is empty
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dmpq_pkg::slot_t left_s;
        dmpq_pkg::slot_t right_s;
        dmpq_pkg::tok_t  tok_in_s;

        if (g == 0) begin : g_head
            assign left_s   = HEAD_SLOT;
            assign tok_in_s = TOK_INIT;
        end else begin : g_mid
            assign left_s   = slots[g-1];
            assign tok_in_s = toks[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_s = TAIL_SLOT;
        end else begin : g_inner
            assign right_s = slots[g+1];
        end

        dmpq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (IDX_W'(g)),
            .cmd       (cmd),
            .left_slot (left_s),
            .right_slot(right_s),
            .flag_in   (flag_chain[g]),
            .flag_out  (flag_chain[g+1]),
            .tok_in    (tok_in_s),
            .tok_out   (toks[g]),
            .slot_out  (slots[g])
        );

        assign valid_vec[g] = slots[g].valid;
    end

    // command broadcast to every cell
    always_comb begin
        cmd.op       = dmpq_pkg::CELL_IDLE;
        cmd.key      = key_reg;
        cmd.rel      = rel_reg;
        cmd.time_now = time_reg;
        cmd.expiry   = expiry_reg;
        cmd.drop_idx = tok_last.idx;
        unique case (state_reg)
            ST_EXEC: begin
                if (op_reg == dmpq_pkg::OP_PUSH) begin
                    cmd.op = dmpq_pkg::CELL_PUSH;
                end else if (op_reg == dmpq_pkg::OP_CLEAR) begin
                    cmd.op = dmpq_pkg::CELL_CLEAR;
                end
            end
            ST_SCAN: begin
                // pop removes the winner in the cycle the token reaches the end
                if (scan_cnt_reg == SCAN_LAST && op_reg == dmpq_pkg::OP_POP
                        && tok_last.found) begin
                    cmd.op = dmpq_pkg::CELL_DROP;
                end
            end
            ST_EXPIRE: begin
                cmd.op = dmpq_pkg::CELL_EXPIRE;
            end
            default: begin
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            time_reg     <= '0;
            scan_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // the result state reloads the output register itself
            if (m_ready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_op;
                        key_reg   <= s_action_key;
                        rel_reg   <= s_relevance;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    res_key_reg <= '0;
                    res_rel_reg <= '0;
                    unique case (op_reg)
                        dmpq_pkg::OP_PUSH: begin
                            res_removed_reg <= '0;
                            state_reg       <= ST_RESULT;
                            // flag chain reports a key match anywhere in the row
                            if (any_flag) begin
                                res_status_reg <= dmpq_pkg::ST_MERGED;
                            end else if (slots[DEPTH-1].valid) begin
                                res_status_reg <= dmpq_pkg::ST_FULL;
                            end else begin
                                res_status_reg <= dmpq_pkg::ST_INSERTED;
                                count_reg      <= count_reg + CNT_W'(1);
                            end
                        end
                        dmpq_pkg::OP_POP, dmpq_pkg::OP_PEEK: begin
                            res_removed_reg <= '0;
                            scan_cnt_reg    <= '0;
                            state_reg       <= ST_SCAN;
                        end
                        dmpq_pkg::OP_EXPIRE: begin
                            res_status_reg  <= dmpq_pkg::ST_DONE;
                            res_removed_reg <= '0;
                            // zero limit turns expiry off
                            if (expiry_reg != '0) begin
                                state_reg <= ST_EXPIRE;
                            end else begin
                                state_reg <= ST_RESULT;
                            end
                        end
                        dmpq_pkg::OP_CLEAR: begin
                            res_status_reg  <= dmpq_pkg::ST_DONE;
                            res_removed_reg <= count_reg;
                            count_reg       <= '0;
                            state_reg       <= ST_RESULT;
                        end
                        dmpq_pkg::OP_TICK: begin
                            res_status_reg  <= dmpq_pkg::ST_DONE;
                            res_removed_reg <= '0;
                            time_reg        <= time_reg + 32'd1;
                            state_reg       <= ST_RESULT;
                        end
                        default: begin
                            res_status_reg  <= dmpq_pkg::ST_DONE;
                            res_removed_reg <= '0;
                            state_reg       <= ST_RESULT;
                        end
                    endcase
                end
                ST_SCAN: begin
                    // the token has to pass every cell before the result is taken
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                    if (scan_cnt_reg == SCAN_LAST) begin
                        state_reg <= ST_RESULT;
                        if (tok_last.found) begin
                            res_status_reg <= dmpq_pkg::ST_DONE;
                            res_key_reg    <= tok_last.key;
                            res_rel_reg    <= tok_last.rel;
                            if (op_reg == dmpq_pkg::OP_POP) begin
                                count_reg <= count_reg - CNT_W'(1);
                            end
                        end else begin
                            res_status_reg <= dmpq_pkg::ST_NONE;
                        end
                    end
                end
                ST_EXPIRE: begin
                    // one expired slot squeezed out per cycle, first one first
                    if (any_flag) begin
                        count_reg       <= count_reg - CNT_W'(1);
                        res_removed_reg <= res_removed_reg + CNT_W'(1);
                    end else begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= res_status_reg;
                        m_key_reg     <= res_key_reg;
                        m_rel_reg     <= res_rel_reg;
                        m_removed_reg <= dmpq_pkg::fit_removed(res_removed_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_out_key       = m_key_reg;
    assign m_out_relevance = m_rel_reg;
    assign m_removed_count = m_removed_reg;

    // register port: expiry_ticks at byte address 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expiry_reg <= '0;
        end else if (cfg_write) begin
            expiry_reg <= pwdata[15:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {16'd0, expiry_reg};

    // occupancy never exceeds the row
    `DMPQ_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    // occupied slots form one block starting at slot 0
    `DMPQ_ASSERT_SAME(a_compact, aclk, aresetn, 1'b1, (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    // fill counter agrees with the cells
    `DMPQ_ASSERT_SAME(a_count_match, aclk, aresetn, 1'b1, $countones(valid_vec) == int'(count_reg))
    // table holds still while the max token walks the row
    `DMPQ_ASSERT_SAME(a_scan_stable, aclk, aresetn, state_reg == ST_SCAN, $stable(valid_vec))
    // a released result shows up on the output next cycle
    `DMPQ_ASSERT_NEXT(a_result_out, aclk, aresetn, state_reg == ST_RESULT && (!m_valid_reg || m_ready), m_valid && state_reg == ST_IDLE)

endmodule

FILE: rtl/dmpq_cell.sv
// one slot of the table with its match, expiry and max-search logic
`timescale 1ns / 1ps
module dmpq_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dmpq_pkg::IDX_W-1:0]    cell_idx,
    input  dmpq_pkg::cell_cmd_t           cmd,
    input  dmpq_pkg::slot_t               left_slot,
    input  dmpq_pkg::slot_t               right_slot,
    input  logic                          flag_in,
    output logic                          flag_out,
    input  dmpq_pkg::tok_t                tok_in,
    output dmpq_pkg::tok_t                tok_out,
    output dmpq_pkg::slot_t               slot_out
);

    dmpq_pkg::slot_t slot_reg;
    dmpq_pkg::slot_t slot_next;
    dmpq_pkg::tok_t  tok_reg;
    dmpq_pkg::tok_t  tok_next;
    logic            hit_key;
    logic            expired;
    logic            local_flag;
    logic [31:0]     age;

    assign hit_key = slot_reg.valid && (slot_reg.key == cmd.key);
    assign age     = cmd.time_now - slot_reg.birth;
    assign expired = slot_reg.valid && (age > {16'b0, cmd.expiry});

    // flag chain: first key match for push, first expired slot for expiry
    always_comb begin
        local_flag = 1'b0;
        if (cmd.op == dmpq_pkg::CELL_PUSH) begin
            local_flag = hit_key;
        end else if (cmd.op == dmpq_pkg::CELL_EXPIRE) begin
            local_flag = expired;
        end
    end
    assign flag_out = flag_in | local_flag;

    always_comb begin
        slot_next = slot_reg;
        unique case (cmd.op)
            dmpq_pkg::CELL_IDLE: begin
            end
            dmpq_pkg::CELL_PUSH: begin
                if (hit_key) begin
                    if (cmd.rel > slot_reg.rel) begin
                        slot_next.rel = cmd.rel;
                    end
                end else if (!slot_reg.valid && left_slot.valid && !flag_in) begin
                    slot_next.valid = 1'b1;
                    slot_next.key   = cmd.key;
                    slot_next.rel   = cmd.rel;
                    slot_next.birth = cmd.time_now;
                end
            end
            dmpq_pkg::CELL_DROP: begin
                if (cell_idx >= cmd.drop_idx) begin
                    slot_next = right_slot;
                end
            end
            dmpq_pkg::CELL_EXPIRE: begin
                if (flag_out) begin
                    slot_next = right_slot;
                end
            end
            dmpq_pkg::CELL_CLEAR: begin
                slot_next.valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // running maximum, strictly greater keeps the earliest slot
    always_comb begin
        tok_next = tok_in;
        if (slot_reg.valid && (slot_reg.rel > tok_in.rel)) begin
            tok_next.found = 1'b1;
            tok_next.rel   = slot_reg.rel;
            tok_next.key   = slot_reg.key;
            tok_next.idx   = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
            tok_reg.found  <= 1'b0;
        end else begin
            slot_reg <= slot_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out  = tok_reg;
    assign slot_out = slot_reg;

endmodule
